// ===== hdl/rbsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared types and codes for the ray/box slab intersection block.
// ----------------------------------------------------------------------------
package rbsi_pkg;

  // Configuration register indexes.
  localparam int CFG_INDEX_WIDTH = 2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_X = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_Y = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_W = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_H = 2'd3;

  // Face normal component: -1, 0 or +1.
  typedef logic signed [1:0] norm_t;
  localparam norm_t NORM_ZERO = 2'sb00;
  localparam norm_t NORM_POS  = 2'sb01;
  localparam norm_t NORM_NEG  = 2'sb11;

  // Side flags that travel with each division lane.
  typedef struct packed {
    logic neg;   // quotient is negative
    logic nneg;  // numerator is negative
    logic dz;    // divisor is zero
  } div_flags_t;

endpackage

// ===== hdl/rbsi_ray_if.sv =====
// ----------------------------------------------------------------------------
// rbsi_ray_if
// Valid/ready channel that carries one ray: origin and direction.
// ----------------------------------------------------------------------------
interface rbsi_ray_if #(parameter int W = 32) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] origin_x;
  logic signed [W-1:0] origin_y;
  logic signed [W-1:0] dir_x;
  logic signed [W-1:0] dir_y;

  modport source (output valid, origin_x, origin_y, dir_x, dir_y, input ready);
  modport sink (input valid, origin_x, origin_y, dir_x, dir_y, output ready);
endinterface

// ===== hdl/rbsi_hit_if.sv =====
// ----------------------------------------------------------------------------
// rbsi_hit_if
// Valid/ready channel that carries one intersection result.
// ----------------------------------------------------------------------------
interface rbsi_hit_if #(parameter int W = 32) ();
  import rbsi_pkg::*;
  logic                valid;
  logic                ready;
  logic                hit;
  logic signed [W-1:0] t_near;
  logic signed [W-1:0] contact_x;
  logic signed [W-1:0] contact_y;
  norm_t               normal_x;
  norm_t               normal_y;

  modport source (output valid, hit, t_near, contact_x, contact_y, normal_x, normal_y,
                  input ready);
  modport sink (input valid, hit, t_near, contact_x, contact_y, normal_x, normal_y,
                output ready);
endinterface

// ===== hdl/rbsi_div_cell.sv =====
// ----------------------------------------------------------------------------
// rbsi_div_cell
// One restoring-divider step: while en is high, produces one quotient bit per
// cycle and hands the partial remainder and shifted quotient to the next cell.
// ----------------------------------------------------------------------------
module rbsi_div_cell #(
  parameter int W  = 32,
  parameter int NB = 49
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [W-1:0]              rem_in,
  input  logic [NB-1:0]             nq_in,
  input  logic [W-1:0]              ud_in,
  input  rbsi_pkg::div_flags_t      flags_in,
  output logic [W-1:0]              rem,
  output logic [NB-1:0]             nq,
  output logic [W-1:0]              ud,
  output rbsi_pkg::div_flags_t      flags
);
  import rbsi_pkg::*;

  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;
  logic [W-1:0]  rem_next;

  // Bring down the next numerator bit and try to subtract the divisor.
  always_comb begin
    trial    = {rem_in, nq_in[NB-1]};
    diff     = trial - {1'b0, ud_in};
    ge       = (trial >= {1'b0, ud_in});
    rem_next = ge ? diff[W-1:0] : trial[W-1:0];
  end

  // Stage registers; the quotient bit shifts in where the numerator bit left.
  always_ff @(posedge clk) begin
    if (en) begin
      rem   <= rem_next;
      nq    <= {nq_in[NB-2:0], ge};
      ud    <= ud_in;
      flags <= flags_in;
    end
  end

endmodule

// ===== hdl/rbsi_contact.sv =====
// ----------------------------------------------------------------------------
// rbsi_contact
// Contact coordinate: origin + (t_near * dir >> FRAC_BITS), saturated.
// Two stages: multiply, then scale, add and clamp.
// ----------------------------------------------------------------------------
module rbsi_contact #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic                hit,
  input  logic signed [W-1:0] tn,
  input  logic signed [W-1:0] dir,
  input  logic signed [W-1:0] origin,
  output logic signed [W-1:0] contact
);
  localparam int PW = 2 * W;
  localparam int SW = PW - F;

  logic [W-1:0]   ua;
  logic [W-1:0]   ub;
  logic [PW-1:0]  prod;
  logic           neg;
  logic           m_hit;
  logic [W-1:0]   m_origin;
  logic [SW-1:0]  slo;
  logic [SW-1:0]  cap;
  logic [W:0]     mag;
  logic [W+1:0]   val;
  logic [W+1:0]   sum;
  logic [W-1:0]   clamped;

  // Magnitudes of both factors.
  always_comb begin
    ua = tn[W-1] ? (W)'(-tn) : tn;
    ub = dir[W-1] ? (W)'(-dir) : dir;
  end

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= ua * ub;
      neg      <= tn[W-1] ^ dir[W-1];
      m_hit    <= hit;
      m_origin <= origin;
    end
  end

  // Drop fraction bits, cap at 2^W, restore sign, add origin and clamp.
  always_comb begin
    slo = prod[PW-1:F];
    cap = SW'({1'b1, {W{1'b0}}});
    mag = (slo > cap) ? cap[W:0] : slo[W:0];
    val = neg ? -{1'b0, mag} : {1'b0, mag};
    sum = {{2{m_origin[W-1]}}, m_origin} + val;
    if ((sum[W+1:W-1] == 3'b000) || (sum[W+1:W-1] == 3'b111)) begin
      clamped = sum[W-1:0];
    end else if (sum[W+1]) begin
      clamped = {1'b1, {(W-1){1'b0}}};
    end else begin
      clamped = {1'b0, {(W-1){1'b1}}};
    end
  end

  // Result register; a miss reports zero.
  always_ff @(posedge clk) begin
    if (en) begin
      contact <= m_hit ? clamped : '0;
    end
  end

endmodule

// ===== hdl/ray_box_slab_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// 2D ray against a configured axis-aligned box by the slab method.
// ----------------------------------------------------------------------------
// The block is fully pipelined and takes one ray per cycle while no result
// waits on the output; coordinates default to Q16.16. The edge that takes the
// ray registers the magnitudes and sign flags of the four slab numerators and
// divisors. Four parallel chains of COORD_WIDTH + FRAC_BITS + 1 divider cells
// then produce one quotient bit each per cycle. A register stage then saturates
// the slab times, the next orders them and picks the entry face, and the
// contact multiply and result stages compute the contact point. The whole
// pipeline holds, and the input is refused, while a result waits on the output.
// Box registers should be written only while no ray is in flight.
module ray_box_slab_intersect #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [rbsi_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]               cfg_data,
  rbsi_ray_if.sink                             ray,
  rbsi_hit_if.source                           result
);
  import rbsi_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int NB = W + 1 + F;
  localparam int NL = 4;
  localparam int SD = NB + 2;
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};

  // Box registers.
  logic signed [W-1:0] box_x;
  logic signed [W-1:0] box_y;
  logic [W-2:0]        box_w;
  logic [W-2:0]        box_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_x <= '0;
      box_y <= '0;
      box_w <= '0;
      box_h <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOX_X: box_x <= cfg_data;
        REG_BOX_Y: box_y <= cfg_data;
        REG_BOX_W: box_w <= cfg_data[W-2:0];
        REG_BOX_H: box_h <= cfg_data[W-2:0];
      endcase
    end
  end

  // Pipeline control: everything advances unless a result is stalled.
  logic          en;
  logic          vp;
  logic [NB-1:0] vc;
  logic          va;
  logic          vb;
  logic          vm;
  logic          vo;

  assign en        = !vo || result.ready;
  assign ray.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
      vc <= '0;
      va <= 1'b0;
      vb <= 1'b0;
      vm <= 1'b0;
      vo <= 1'b0;
    end else if (en) begin
      vp <= ray.valid;
      vc <= {vc[NB-2:0], vp};
      va <= vc[NB-1];
      vb <= va;
      vm <= vb;
      vo <= vm;
    end
  end

  // Slab numerators and divisors for the four lanes.
  logic [W+1:0] num [NL];
  logic [W-1:0] den [NL];
  logic [W+1:0] bx_e;
  logic [W+1:0] by_e;
  logic [W+1:0] ox_e;
  logic [W+1:0] oy_e;

  always_comb begin
    bx_e   = {{2{box_x[W-1]}}, box_x};
    by_e   = {{2{box_y[W-1]}}, box_y};
    ox_e   = {{2{ray.origin_x[W-1]}}, ray.origin_x};
    oy_e   = {{2{ray.origin_y[W-1]}}, ray.origin_y};
    num[0] = bx_e - ox_e;
    num[1] = bx_e + {3'b000, box_w} - ox_e;
    num[2] = by_e - oy_e;
    num[3] = by_e + {3'b000, box_h} - oy_e;
    den[0] = ray.dir_x;
    den[1] = ray.dir_x;
    den[2] = ray.dir_y;
    den[3] = ray.dir_y;
  end

  // Prep stage: magnitudes and sign flags.
  logic [W:0]   p_un    [NL];
  logic [W-1:0] p_ud    [NL];
  div_flags_t   p_flags [NL];

  // Divider chains.
  logic [W-1:0]  c_rem   [NL][NB];
  logic [NB-1:0] c_nq    [NL][NB];
  logic [W-1:0]  c_ud    [NL][NB];
  div_flags_t    c_flags [NL][NB];
  logic [W-1:0]  i_rem   [NL][NB];
  logic [NB-1:0] i_nq    [NL][NB];
  logic [W-1:0]  i_ud    [NL][NB];
  div_flags_t    i_flags [NL][NB];

  // Saturated slab times.
  logic [W-1:0] t_div [NL];
  logic [W-1:0] a_t   [NL];

  for (genvar l = 0; l < NL; l++) begin : g_lane
    logic [W+1:0] nabs;
    logic [W-1:0] dabs;
    logic [NB-1:0] q;
    logic [NB-1:0] limit;
    logic [W-1:0]  qneg;

    always_comb begin
      nabs = num[l][W+1] ? -num[l] : num[l];
      dabs = den[l][W-1] ? -den[l] : den[l];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p_un[l]         <= nabs[W:0];
        p_ud[l]         <= dabs;
        p_flags[l].neg  <= num[l][W+1] ^ den[l][W-1];
        p_flags[l].nneg <= num[l][W+1];
        p_flags[l].dz   <= (den[l] == '0);
      end
    end

    for (genvar k = 0; k < NB; k++) begin : g_cell
      if (k == 0) begin : g_first
        assign i_rem[l][k]   = '0;
        assign i_nq[l][k]    = {p_un[l], {F{1'b0}}};
        assign i_ud[l][k]    = p_ud[l];
        assign i_flags[l][k] = p_flags[l];
      end else begin : g_next
        assign i_rem[l][k]   = c_rem[l][k-1];
        assign i_nq[l][k]    = c_nq[l][k-1];
        assign i_ud[l][k]    = c_ud[l][k-1];
        assign i_flags[l][k] = c_flags[l][k-1];
      end

      rbsi_div_cell #(.W(W), .NB(NB)) u_cell (
        .clk      (clk),
        .en       (en),
        .rem_in   (i_rem[l][k]),
        .nq_in    (i_nq[l][k]),
        .ud_in    (i_ud[l][k]),
        .flags_in (i_flags[l][k]),
        .rem      (c_rem[l][k]),
        .nq       (c_nq[l][k]),
        .ud       (c_ud[l][k]),
        .flags    (c_flags[l][k])
      );
    end

    // Sign, saturation and the zero-divisor rule.
    always_comb begin
      q     = c_nq[l][NB-1];
      limit = c_flags[l][NB-1].neg ? NB'(SMIN) : NB'(SMAX);
      qneg  = -q[W-1:0];
      if (c_flags[l][NB-1].dz) begin
        t_div[l] = c_flags[l][NB-1].nneg ? SMIN : SMAX;
      end else if (q > limit) begin
        t_div[l] = c_flags[l][NB-1].neg ? SMIN : SMAX;
      end else begin
        t_div[l] = c_flags[l][NB-1].neg ? qneg : q[W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_t[l] <= t_div[l];
      end
    end
  end

  // Ray sideband, delayed to line up with the slab times.
  logic [W-1:0] sb_ox [SD];
  logic [W-1:0] sb_oy [SD];
  logic [W-1:0] sb_dx [SD];
  logic [W-1:0] sb_dy [SD];

  always_ff @(posedge clk) begin
    if (en) begin
      sb_ox[0] <= ray.origin_x;
      sb_oy[0] <= ray.origin_y;
      sb_dx[0] <= ray.dir_x;
      sb_dy[0] <= ray.dir_y;
      for (int i = 1; i < SD; i++) begin
        sb_ox[i] <= sb_ox[i-1];
        sb_oy[i] <= sb_oy[i-1];
        sb_dx[i] <= sb_dx[i-1];
        sb_dy[i] <= sb_dy[i-1];
      end
    end
  end

  // Order the slab times, test overlap and pick the entry face.
  logic signed [W-1:0] tnx, tfx, tny, tfy, tn, tf;
  logic                hit_c;
  norm_t               nx_c, ny_c;

  always_comb begin
    if ($signed(a_t[0]) > $signed(a_t[1])) begin
      tnx = a_t[1];
      tfx = a_t[0];
    end else begin
      tnx = a_t[0];
      tfx = a_t[1];
    end
    if ($signed(a_t[2]) > $signed(a_t[3])) begin
      tny = a_t[3];
      tfy = a_t[2];
    end else begin
      tny = a_t[2];
      tfy = a_t[3];
    end
    tn    = (tnx > tny) ? tnx : tny;
    tf    = (tfx < tfy) ? tfx : tfy;
    hit_c = !((tnx > tfy) || (tny > tfx)) && !tf[W-1];
    nx_c  = NORM_ZERO;
    ny_c  = NORM_ZERO;
    if (tnx > tny) begin
      nx_c = sb_dx[SD-1][W-1] ? NORM_POS : NORM_NEG;
    end else if (tnx < tny) begin
      ny_c = sb_dy[SD-1][W-1] ? NORM_POS : NORM_NEG;
    end
  end

  logic                b_hit;
  logic signed [W-1:0] b_tn;
  norm_t               b_nx, b_ny;
  logic signed [W-1:0] b_ox, b_oy, b_dx, b_dy;

  always_ff @(posedge clk) begin
    if (en) begin
      b_hit <= hit_c;
      b_tn  <= hit_c ? tn : '0;
      b_nx  <= hit_c ? nx_c : NORM_ZERO;
      b_ny  <= hit_c ? ny_c : NORM_ZERO;
      b_ox  <= sb_ox[SD-1];
      b_oy  <= sb_oy[SD-1];
      b_dx  <= sb_dx[SD-1];
      b_dy  <= sb_dy[SD-1];
    end
  end

  // Contact point, two stages per axis.
  logic signed [W-1:0] cx, cy;

  rbsi_contact #(.W(W), .F(F)) u_contact_x (
    .clk     (clk),
    .en      (en),
    .hit     (b_hit),
    .tn      (b_tn),
    .dir     (b_dx),
    .origin  (b_ox),
    .contact (cx)
  );

  rbsi_contact #(.W(W), .F(F)) u_contact_y (
    .clk     (clk),
    .en      (en),
    .hit     (b_hit),
    .tn      (b_tn),
    .dir     (b_dy),
    .origin  (b_oy),
    .contact (cy)
  );

  // Matching delay for the other result fields.
  logic                m_hit, o_hit;
  logic signed [W-1:0] m_tn, o_tn;
  norm_t               m_nx, m_ny, o_nx, o_ny;

  always_ff @(posedge clk) begin
    if (en) begin
      m_hit <= b_hit;
      m_tn  <= b_tn;
      m_nx  <= b_nx;
      m_ny  <= b_ny;
      o_hit <= m_hit;
      o_tn  <= m_tn;
      o_nx  <= m_nx;
      o_ny  <= m_ny;
    end
  end

  assign result.valid     = vo;
  assign result.hit       = o_hit;
  assign result.t_near    = o_tn;
  assign result.contact_x = cx;
  assign result.contact_y = cy;
  assign result.normal_x  = o_nx;
  assign result.normal_y  = o_ny;

`ifndef ASSERT_OFF
  // Input is refused only while a finished result waits.
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !ray.ready |-> (vo && !result.ready))
    else $error("input stalled without a waiting result");

  // A miss carries all-zero result fields.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (vo && !o_hit) |-> (o_tn == '0 && cx == '0 && cy == '0 &&
                        o_nx == NORM_ZERO && o_ny == NORM_ZERO))
    else $error("miss with nonzero fields");

  // At most one normal component is set.
  a_one_normal: assert property (@(posedge clk) disable iff (rst)
    vo |-> (o_nx == NORM_ZERO || o_ny == NORM_ZERO))
    else $error("both normal components set");

  // An item in the multiply stage reaches the output when the pipeline advances.
  a_valid_advance: assert property (@(posedge clk) disable iff (rst)
    (en && vm) |=> vo)
    else $error("result lost between pipeline stages");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ray_box_slab_intersect. Rays are sent over the ray
// channel; a fixed-point slab predictor, or a typed row's known answer, gives
// each expectation; hit channel results are compared per field, in order.
// ----------------------------------------------------------------------------
module testbench;
  import rbsi_pkg::*;

  localparam int       W          = 32;
  localparam int       FRAC       = 16;
  localparam longint   SMAX       = 64'sh0000_0000_7FFF_FFFF;
  localparam longint   SMIN       = -SMAX - 1;
  localparam int       LATENCY    = W + FRAC + 6;
  localparam int       STALL_LIMIT = 5000;
  localparam int       HOLD_CYCLES = 400;
  localparam logic [31:0] ONE     = 32'h0001_0000;

  // Idle patterns for the two channels.
  typedef enum int {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SNK_STALL, FLOW_BOTH} flow_e;

  typedef struct {
    logic signed [W-1:0] origin_x;
    logic signed [W-1:0] origin_y;
    logic signed [W-1:0] dir_x;
    logic signed [W-1:0] dir_y;
  } ray_item_t;

  typedef struct {
    logic                hit;
    logic signed [W-1:0] t_near;
    logic signed [W-1:0] contact_x;
    logic signed [W-1:0] contact_y;
    norm_t               normal_x;
    norm_t               normal_y;
  } hit_result_t;

  typedef struct {
    ray_item_t   ray;
    bit          typed;
    hit_result_t want;
  } ray_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_BOX_X;
  logic [W-1:0] cfg_data = '0;

  rbsi_ray_if #(.W(W)) ray_ch ();
  rbsi_hit_if #(.W(W)) hit_ch ();

  ray_box_slab_intersect #(.COORD_WIDTH(W), .FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .ray(ray_ch), .result(hit_ch)
  );

  always #5 clk = ~clk;

  // Box as the predictor sees it.
  logic signed [W-1:0] box_x = '0;
  logic signed [W-1:0] box_y = '0;
  logic [W-2:0]        box_w = '0;
  logic [W-2:0]        box_h = '0;

  hit_result_t pending_hits[$];
  flow_e       flow = FLOW_FREE;
  bit          hold_request = 0;
  int          errors = 0;
  int          rays_sent = 0;
  int          hits_seen = 0;
  int          misses_seen = 0;
  int          idle_cycles = 0;
  int          box_settings = 0;
  ray_row_t    rows[$];

  // Slab time: (n << FRAC) / d truncated toward zero and saturated; a zero
  // direction saturates with the sign of the numerator.
  function automatic longint slab_time(longint n, longint d);
    bit          neg;
    bit [63:0]   un, ud, q, limit;
    if (d == 0) return (n < 0) ? SMIN : SMAX;
    neg   = (n < 0) != (d < 0);
    un    = (n < 0) ? -n : n;
    ud    = (d < 0) ? -d : d;
    q     = (un << FRAC) / ud;
    limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (q > limit) return neg ? SMIN : SMAX;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // Fixed-point product truncated toward zero, capped at 2^W in magnitude.
  function automatic longint scaled_product(longint a, longint b);
    bit [63:0] ua, ub, m;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    m  = (ua * ub) >> FRAC;
    if (m > 64'h1_0000_0000) m = 64'h1_0000_0000;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  // Expected result of one ray against the current box.
  function automatic hit_result_t predict_hit(ray_item_t r);
    hit_result_t res;
    longint ox, oy, dx, dy, enter_x, exit_x, enter_y, exit_y, swap, t_in, t_out;
    ox = r.origin_x; oy = r.origin_y; dx = r.dir_x; dy = r.dir_y;
    res = '{hit: 1'b0, t_near: '0, contact_x: '0, contact_y: '0,
            normal_x: NORM_ZERO, normal_y: NORM_ZERO};
    enter_x = slab_time(longint'(box_x) - ox, dx);
    exit_x  = slab_time(longint'(box_x) + longint'(box_w) - ox, dx);
    enter_y = slab_time(longint'(box_y) - oy, dy);
    exit_y  = slab_time(longint'(box_y) + longint'(box_h) - oy, dy);
    if (enter_x > exit_x) begin
      swap = enter_x; enter_x = exit_x; exit_x = swap;
    end
    if (enter_y > exit_y) begin
      swap = enter_y; enter_y = exit_y; exit_y = swap;
    end
    if (enter_x > exit_y || enter_y > exit_x) return res;
    t_in  = (enter_x > enter_y) ? enter_x : enter_y;
    t_out = (exit_x < exit_y) ? exit_x : exit_y;
    if (t_out < 0) return res;
    res.hit       = 1'b1;
    res.t_near    = t_in[W-1:0];
    res.contact_x = W'(clamp_coord(ox + scaled_product(t_in, dx)));
    res.contact_y = W'(clamp_coord(oy + scaled_product(t_in, dy)));
    if (enter_x > enter_y) res.normal_x = (dx < 0) ? NORM_POS : NORM_NEG;
    else if (enter_x < enter_y) res.normal_y = (dy < 0) ? NORM_POS : NORM_NEG;
    return res;
  endfunction

  // Random ray: mostly aimed around the box, some fully random fields.
  function automatic ray_item_t random_ray();
    ray_item_t r;
    longint span_x, span_y;
    bit [63:0] pick;
    if ($urandom_range(99) < 20) begin
      r = '{$urandom, $urandom, $urandom, $urandom};
      return r;
    end
    span_x = 64'h8_0000 + longint'(box_w) / 2;
    span_y = 64'h8_0000 + longint'(box_h) / 2;
    pick = {$urandom, $urandom};
    r.origin_x = W'(longint'(box_x) - span_x + longint'(pick % (box_w + 2 * span_x + 1)));
    pick = {$urandom, $urandom};
    r.origin_y = W'(longint'(box_y) - span_y + longint'(pick % (box_h + 2 * span_y + 1)));
    case ($urandom_range(9))
      0: r.dir_x = '0;
      1: r.dir_x = $urandom;
      default: r.dir_x = W'(longint'($urandom_range(32'h8_0000)) - 64'h4_0000);
    endcase
    case ($urandom_range(9))
      0: r.dir_y = '0;
      1: r.dir_y = $urandom;
      default: r.dir_y = W'(longint'($urandom_range(32'h8_0000)) - 64'h4_0000);
    endcase
    return r;
  endfunction

  function automatic bit idle_roll(bit on_source);
    case (flow)
      FLOW_SRC_IDLE:  return on_source ? ($urandom_range(99) < 85) : 1'b0;
      FLOW_SNK_STALL: return on_source ? 1'b0 : ($urandom_range(99) < 85);
      FLOW_BOTH:      return $urandom_range(99) < 10;
      default:        return 1'b0;
    endcase
  endfunction

  // Writes all four box registers on consecutive edges.
  task automatic write_box(logic [W-1:0] x, logic [W-1:0] y, logic [W-1:0] w,
                           logic [W-1:0] h);
    logic [W-1:0] vals[4];
    logic [CFG_INDEX_WIDTH-1:0] idx[4];
    vals = '{x, y, w, h};
    idx  = '{REG_BOX_X, REG_BOX_Y, REG_BOX_W, REG_BOX_H};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    box_x = x; box_y = y; box_w = w[W-2:0]; box_h = h[W-2:0];
    box_settings++;
  endtask

  // One ray transfer; the expectation is queued on acceptance.
  task automatic send_ray(ray_item_t r, bit typed, hit_result_t want);
    int gap;
    gap = 0;
    while (idle_roll(1'b1)) gap++;
    if (gap > 0) begin
      ray_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ray_ch.valid    <= 1'b1;
    ray_ch.origin_x <= r.origin_x;
    ray_ch.origin_y <= r.origin_y;
    ray_ch.dir_x    <= r.dir_x;
    ray_ch.dir_y    <= r.dir_y;
    do @(posedge clk); while (!ray_ch.ready);
    pending_hits.push_back(typed ? want : predict_hit(r));
    rays_sent++;
  endtask

  task automatic drain();
    ray_ch.valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(flow_e mode, int count, bit with_hold);
    hit_result_t none;
    none = '{1'b0, '0, '0, '0, NORM_ZERO, NORM_ZERO};
    flow = mode;
    if (with_hold) hold_request = 1;
    for (int i = 0; i < count; i++) send_ray(random_ray(), 1'b0, none);
    drain();
  endtask

  function automatic void add_row(logic [W-1:0] ox, logic [W-1:0] oy, logic [W-1:0] dx,
                                  logic [W-1:0] dy, bit typed, hit_result_t want);
    ray_row_t row;
    row.ray   = '{ox, oy, dx, dy};
    row.typed = typed;
    row.want  = want;
    rows.push_back(row);
  endfunction

  // Receiver: random stalls per mode, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    hit_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        hit_ch.ready <= 1'b0;
      end else if (hold_request && !rst) begin
        hold_request = 0;
        hold_left = HOLD_CYCLES;
        hit_ch.ready <= 1'b0;
      end else begin
        hit_ch.ready <= !rst && !idle_roll(1'b0);
      end
    end
  end

  // Result checker: each transfer against the oldest expectation.
  always @(posedge clk) begin
    hit_result_t want;
    if (!rst && hit_ch.valid && hit_ch.ready) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result, hit=%0b t_near=%h", $time, hit_ch.hit,
                 hit_ch.t_near);
        errors++;
      end else begin
        want = pending_hits.pop_front();
        if (hit_ch.hit) hits_seen++; else misses_seen++;
        if (hit_ch.hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit_ch.hit);
          errors++;
        end
        if (hit_ch.t_near !== want.t_near) begin
          $display("%0t: t_near expected %h actual %h", $time, want.t_near, hit_ch.t_near);
          errors++;
        end
        if (hit_ch.contact_x !== want.contact_x) begin
          $display("%0t: contact_x expected %h actual %h", $time, want.contact_x,
                   hit_ch.contact_x);
          errors++;
        end
        if (hit_ch.contact_y !== want.contact_y) begin
          $display("%0t: contact_y expected %h actual %h", $time, want.contact_y,
                   hit_ch.contact_y);
          errors++;
        end
        if (hit_ch.normal_x !== want.normal_x) begin
          $display("%0t: normal_x expected %0d actual %0d", $time, want.normal_x,
                   hit_ch.normal_x);
          errors++;
        end
        if (hit_ch.normal_y !== want.normal_y) begin
          $display("%0t: normal_y expected %0d actual %0d", $time, want.normal_y,
                   hit_ch.normal_y);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((ray_ch.valid && ray_ch.ready) || (hit_ch.valid && hit_ch.ready) || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("ray_box_slab_intersect test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    hit_result_t none, far_hit, corner_hit;
    none       = '{1'b0, '0, '0, '0, NORM_ZERO, NORM_ZERO};
    far_hit    = '{1'b1, 32'h7FFF_FFFF, '0, '0, NORM_ZERO, NORM_ZERO};
    corner_hit = '{1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, NORM_ZERO, NORM_ZERO};

    ray_ch.valid = 1'b0;
    ray_ch.origin_x = '0; ray_ch.origin_y = '0;
    ray_ch.dir_x = '0; ray_ch.dir_y = '0;

    // Rows against the empty box at reset: known answers.
    add_row(-ONE, '0, ONE, '0, 1'b1, none);
    add_row('0, '0, '0, '0, 1'b1, far_hit);
    add_row(32'h8000_0000, 32'h8000_0000, '0, '0, 1'b1, corner_hit);
    // Rows against the unit test box (1,1)-(3,3).
    add_row('0, 2 * ONE, ONE, '0, 1'b0, none);          // left face
    add_row(4 * ONE, 2 * ONE, -ONE, '0, 1'b0, none);    // right face
    add_row(2 * ONE, '0, '0, ONE, 1'b0, none);          // bottom face
    add_row(2 * ONE, 4 * ONE, '0, -ONE, 1'b0, none);    // top face
    add_row('0, '0, ONE, ONE, 1'b0, none);              // exact corner tie
    add_row(4 * ONE, 2 * ONE, ONE, '0, 1'b0, none);     // box behind the ray
    add_row(2 * ONE, 2 * ONE, ONE, '0, 1'b0, none);     // start inside
    add_row('0, 4 * ONE, ONE, '0, 1'b0, none);          // pass above
    add_row(2 * ONE, 2 * ONE, '0, '0, 1'b0, none);      // still, inside
    add_row('0, '0, '0, '0, 1'b0, none);                // still, outside
    add_row('0, 2 * ONE, 32'h1, '0, 1'b0, none);        // tiny step saturates
    add_row('0, ONE, ONE, '0, 1'b0, none);              // grazing the edge
    add_row(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, none);
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0, none);
    add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, none);
    add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, none);
    add_row(32'h7FFF_FFFF, '0, 32'h8000_0000, 32'h0000_8000, 1'b0, none);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < 3; i++) send_ray(rows[i].ray, rows[i].typed, rows[i].want);
    drain();
    write_box(ONE, ONE, 2 * ONE, 2 * ONE);
    for (int i = 3; i < rows.size(); i++) send_ray(rows[i].ray, rows[i].typed, rows[i].want);
    drain();

    // Random phases over several boxes, the extremes among them.
    write_box(32'hFFFC_8000, 32'hFFFE_0000, 5 * ONE, 4 * ONE);
    random_phase(FLOW_FREE, 250, 1'b0);
    write_box(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    random_phase(FLOW_SRC_IDLE, 150, 1'b0);
    write_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, '0);
    random_phase(FLOW_SNK_STALL, 250, 1'b1);
    write_box(W'({$urandom_range(255), 16'h0} - (128 * ONE)), $urandom,
              $urandom_range(32 * ONE), $urandom_range(32 * ONE));
    random_phase(FLOW_BOTH, 250, 1'b0);
    write_box($urandom, $urandom, $urandom, $urandom);
    random_phase(FLOW_FREE, 200, 1'b1);
    write_box(-ONE, 2 * ONE, ONE / 2, 6 * ONE);
    random_phase(FLOW_SNK_STALL, 180, 1'b0);
    write_box(10 * ONE, -10 * ONE, '0, 3 * ONE);
    random_phase(FLOW_SRC_IDLE, 150, 1'b0);

    flow = FLOW_FREE;
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d rays over %0d box settings: %0d hits, %0d misses checked.",
             rays_sent, box_settings, hits_seen, misses_seen);
    if (errors == 0 && pending_hits.size() == 0) begin
      $display("ray_box_slab_intersect test passed");
    end else begin
      $display("ray_box_slab_intersect test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rbsi_pkg.sv
hdl/rbsi_ray_if.sv
hdl/rbsi_hit_if.sv
hdl/rbsi_div_cell.sv
hdl/rbsi_contact.sv
hdl/ray_box_slab_intersect.sv
tb/sv/testbench.sv
